// ===== hw/rtl/capacitive_touch_key_qualifier_unit_macros.svh =====
// Assertion macros shared by the touch key qualifier RTL.
`ifndef CAPACITIVE_TOUCH_KEY_QUALIFIER_UNIT_MACROS_SVH
`define CAPACITIVE_TOUCH_KEY_QUALIFIER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTKQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CTKQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ctkq_pkg.sv =====
// Shared constants and codes of the touch key qualifier.
package ctkq_pkg;

	localparam int VALUE_W   = 16;  // charge time and baseline width
	localparam int COUNT_W   = 8;   // scan length and lockout width
	localparam int FUNC_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TRIM      = 2;   // samples dropped at each end of the sorted set

	localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_RESTART  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_OVERFLOW = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GATE_MARGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_SAMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CONT_SAMP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONT_MODE    = 3'd4;

	localparam logic KIND_CAL  = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

endpackage

// ===== hw/rtl/ctkq_channels.sv =====
// Valid/ready channel interfaces for measurement input and report output.
interface ctkq_meas_if;
	logic                          valid;
	logic                          ready;
	logic [ctkq_pkg::FUNC_W-1:0]   func;
	logic [ctkq_pkg::VALUE_W-1:0]  charge_time;

	modport source (output valid, output func, output charge_time, input ready);
	modport sink   (input valid, input func, input charge_time, output ready);
endinterface

interface ctkq_report_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic                          pressed;
	logic                          calibration_ok;
	logic [ctkq_pkg::VALUE_W-1:0]  measured_value;

	modport source (output valid, output kind, output pressed, output calibration_ok,
		output measured_value, input ready);
	modport sink   (input valid, input kind, input pressed, input calibration_ok,
		input measured_value, output ready);
endinterface

// ===== hw/rtl/capacitive_touch_key_qualifier_unit.sv =====
// Touch key qualifier: calibration store, trimmed-mean baseline and scan press detection.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------------
//  meas     | in  | valid / ready | func, charge_time
//  report   | out | valid / ready | kind, pressed, calibration_ok, measured_value
//  cfg      | in  | cfg_we        | cfg_idx, cfg_data (write only)
//
// Samples, restarts and overflow items are accepted back to back while idle. The sample
// that completes calibration is followed by a sweep of the calibration memory (one read
// port, one entry a cycle), a reciprocal multiplication by the constant trimmed count,
// then the posting of the result once the report register is free.
// No input is taken meanwhile.
// Reset clears all control state; the calibration memory is not cleared and is only
// read after being filled. A waiting report stalls only an item that would report.
`include "capacitive_touch_key_qualifier_unit_macros.svh"

module capacitive_touch_key_qualifier_unit #(
	parameter int CAL_SAMPLES  = 10,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ctkq_meas_if.sink                        meas,
	ctkq_report_if.source                    report,
	input  logic                             cfg_we,
	input  logic [ctkq_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ctkq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ctkq_pkg::*;

	// Effective sample width: the charge time field is never wider than VALUE_W.
	localparam int SW   = (SAMPLE_WIDTH < VALUE_W) ? SAMPLE_WIDTH : VALUE_W;
	localparam int IW   = $clog2(CAL_SAMPLES);
	localparam int CW   = $clog2(CAL_SAMPLES + 1);
	localparam int SUMW = SW + $clog2(CAL_SAMPLES);
	localparam int DIV  = CAL_SAMPLES - 2 * TRIM;
	// Reciprocal of the trimmed count, exact for every SUMW-bit dividend.
	localparam int DSH  = SUMW + $clog2(DIV);
	localparam int MW   = DSH + 1;
	localparam longint unsigned RECIP = ((64'd1 << DSH) + 64'(DIV) - 64'd1) / 64'(DIV);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	// Configuration registers
	logic [VALUE_W-1:0] gate_q, tmax_q;
	logic [COUNT_W-1:0] nsamp_q, csamp_q;
	logic               cmode_q;

	// Detector state
	logic [1:0]         state_q;
	logic [CW-1:0]      cal_count_q;
	logic               calibrated_q;
	logic [VALUE_W-1:0] baseline_q;
	logic [COUNT_W-1:0] lockout_q;
	logic [COUNT_W-1:0] scan_count_q;
	logic [SW-1:0]      scan_max_q;

	// Calibration memory and sweep datapath
	logic [SW-1:0]      cal_mem [CAL_SAMPLES];
	logic [CW-1:0]      rd_idx_q;
	logic               rd_vld_s1;
	logic [SW-1:0]      rd_data_s1;
	logic [SUMW-1:0]    sum_q;
	logic [SW-1:0]      lo1_q, lo2_q, hi1_q, hi2_q;

	// Divider
	logic [SUMW-1:0]    div_q;
	logic [SW-1:0]      quot_q;

	// Report register
	logic               out_valid_q;
	logic               out_kind_q, out_pressed_q, out_ok_q;
	logic [VALUE_W-1:0] out_value_q;

	// ---------------------------------------------------------------------------------
	// Configuration writes; indexes beyond the list are dropped.
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q  <= VALUE_W'(100);
			tmax_q  <= '1;
			nsamp_q <= COUNT_W'(3);
			csamp_q <= COUNT_W'(1);
			cmode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GATE_MARGIN: gate_q  <= cfg_data[VALUE_W-1:0];
				REG_TIMER_MAX:   tmax_q  <= cfg_data[VALUE_W-1:0];
				REG_NORMAL_SAMP: nsamp_q <= cfg_data[COUNT_W-1:0];
				REG_CONT_SAMP:   csamp_q <= cfg_data[COUNT_W-1:0];
				REG_CONT_MODE:   cmode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Scan arithmetic for the item on the input channel.
	// ---------------------------------------------------------------------------------
	logic [SW-1:0]      sample;
	logic               is_sample, cal_last, scan_first, scan_end, over_gate;
	logic [COUNT_W-1:0] lock_eff, cnt_inc, scan_len, lock_reload, lock_next;
	logic [SW-1:0]      max_base, max_new;
	logic [VALUE_W:0]   gate_sum;
	logic               report_free, emit_scan, accept;

	assign sample     = meas.charge_time[SW-1:0];
	assign is_sample  = (meas.func == FUNC_SAMPLE);
	assign cal_last   = (cal_count_q == CW'(CAL_SAMPLES - 1));
	assign scan_first = (scan_count_q == '0);
	// Continuous mode releases the lockout as each scan opens.
	assign lock_eff   = (scan_first && cmode_q) ? '0 : lockout_q;
	assign max_base   = scan_first ? '0 : scan_max_q;
	assign max_new    = (sample > max_base) ? sample : max_base;
	assign cnt_inc    = (scan_count_q != '1) ? scan_count_q + COUNT_W'(1) : scan_count_q;

	always_comb begin
		scan_len = cmode_q ? csamp_q : nsamp_q;
		if (scan_len == '0) begin
			scan_len = COUNT_W'(1);
		end
	end

	assign scan_end    = (cnt_inc >= scan_len);
	assign gate_sum    = {1'b0, baseline_q} + {1'b0, gate_q};
	assign over_gate   = ((VALUE_W + 1)'(max_new) > gate_sum);
	assign lock_reload = over_gate ? nsamp_q : lock_eff;
	assign lock_next   = (lock_reload != '0) ? lock_reload - COUNT_W'(1) : lock_reload;

	assign report_free = !out_valid_q || report.ready;
	assign emit_scan   = is_sample && calibrated_q && scan_end;
	// Items that post nothing pass even while a report waits.
	assign meas.ready  = (state_q == ST_IDLE) && (report_free || !emit_scan);
	assign accept      = meas.valid && meas.ready;

	// ---------------------------------------------------------------------------------
	// Calibration memory: write at the fill count, read one entry a cycle in the sweep.
	// ---------------------------------------------------------------------------------
	logic wr_en, rd_en;

	assign wr_en = accept && is_sample && !calibrated_q;
	assign rd_en = (state_q == ST_SWEEP) && (rd_idx_q != CW'(CAL_SAMPLES));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cal_mem[cal_count_q[IW-1:0]] <= sample;
		end
		if (rd_en) begin
			rd_data_s1 <= cal_mem[rd_idx_q[IW-1:0]];
		end
	end

	// ---------------------------------------------------------------------------------
	// Trimmed sum: total less the two lowest and two highest entries.
	// ---------------------------------------------------------------------------------
	logic [SUMW-1:0]    mid_sum;
	logic [SUMW+MW-1:0] prod;
	logic [SW-1:0]      quot;
	logic               quot_ok;

	assign mid_sum = sum_q - SUMW'(lo1_q) - SUMW'(lo2_q) - SUMW'(hi1_q) - SUMW'(hi2_q);
	assign prod    = (SUMW + MW)'(div_q) * (SUMW + MW)'(RECIP);
	assign quot    = quot_q;
	assign quot_ok = (VALUE_W'(quot) <= (tmax_q >> 1));

	always_ff @(posedge clk) begin
		if (accept && is_sample && !calibrated_q && cal_last) begin
			sum_q    <= '0;
			lo1_q    <= '1;
			lo2_q    <= '1;
			hi1_q    <= '0;
			hi2_q    <= '0;
			rd_idx_q <= '0;
		end else if (state_q == ST_SWEEP) begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (rd_vld_s1) begin
				sum_q <= sum_q + SUMW'(rd_data_s1);
				if (rd_data_s1 < lo1_q) begin
					lo2_q <= lo1_q;
					lo1_q <= rd_data_s1;
				end else if (rd_data_s1 < lo2_q) begin
					lo2_q <= rd_data_s1;
				end
				if (rd_data_s1 > hi1_q) begin
					hi2_q <= hi1_q;
					hi1_q <= rd_data_s1;
				end else if (rd_data_s1 > hi2_q) begin
					hi2_q <= rd_data_s1;
				end
			end else if (!rd_en) begin
				// Sweep drained: load the divider.
				div_q <= mid_sum;
			end
		end else if (state_q == ST_DIV) begin
			// Divide by the constant trimmed count through its reciprocal.
			quot_q <= prod[DSH +: SW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequencer and detector state.
	// ---------------------------------------------------------------------------------
	logic load_cal;

	assign load_cal = (state_q == ST_EMIT) && report_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cal_count_q  <= '0;
			calibrated_q <= 1'b0;
			baseline_q   <= '0;
			lockout_q    <= '0;
			scan_count_q <= '0;
			scan_max_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (meas.func)
							FUNC_RESTART: begin
								cal_count_q  <= '0;
								calibrated_q <= 1'b0;
								scan_count_q <= '0;
								scan_max_q   <= '0;
							end
							FUNC_OVERFLOW: begin
								baseline_q <= tmax_q;
							end
							FUNC_SAMPLE: begin
								if (!calibrated_q) begin
									cal_count_q <= cal_count_q + CW'(1);
									if (cal_last) begin
										state_q <= ST_SWEEP;
									end
								end else begin
									scan_max_q <= max_new;
									if (scan_end) begin
										scan_count_q <= '0;
										lockout_q    <= lock_next;
									end else begin
										scan_count_q <= cnt_inc;
										lockout_q    <= lock_eff;
									end
								end
							end
							default: ;  // unused code: ignore
						endcase
					end
				end
				ST_SWEEP: begin
					if (!rd_en && !rd_vld_s1) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (report_free) begin
						baseline_q   <= VALUE_W'(quot);
						calibrated_q <= 1'b1;
						cal_count_q  <= '0;
						scan_count_q <= '0;
						scan_max_q   <= '0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Report register: hold until taken, load scan or calibration results.
	// ---------------------------------------------------------------------------------
	logic load_scan;

	assign load_scan = accept && emit_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_scan || load_cal) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_scan) begin
			out_kind_q    <= KIND_SCAN;
			out_pressed_q <= over_gate && (lock_eff == '0);
			out_ok_q      <= (baseline_q <= (tmax_q >> 1));
			out_value_q   <= VALUE_W'(max_new);
		end else if (load_cal) begin
			out_kind_q    <= KIND_CAL;
			out_pressed_q <= 1'b0;
			out_ok_q      <= quot_ok;
			out_value_q   <= VALUE_W'(quot);
		end
	end

	assign report.valid          = out_valid_q;
	assign report.kind           = out_kind_q;
	assign report.pressed        = out_pressed_q;
	assign report.calibration_ok = out_ok_q;
	assign report.measured_value = out_value_q;

	// ---------------------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------------------
	`CTKQ_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, cal_count_q <= CW'(CAL_SAMPLES),
		"calibration fill count beyond store depth")
	`CTKQ_ASSERT_NOW(a_sweep_full, clk, arst_n, $rose(state_q == ST_SWEEP),
		cal_count_q == CW'(CAL_SAMPLES), "sweep started before the store was full")
	`CTKQ_ASSERT_NOW(a_busy_uncal, clk, arst_n, state_q != ST_IDLE, !calibrated_q,
		"calibration sequence running while calibrated")
	`CTKQ_ASSERT_NOW(a_quot_fits, clk, arst_n, state_q == ST_DIV, (prod >> (DSH + SW)) == '0,
		"trimmed mean exceeds sample width")
	`CTKQ_ASSERT_NEXT(a_cal_report, clk, arst_n, load_cal,
		report.valid && (report.kind == KIND_CAL) && !report.pressed && calibrated_q,
		"calibration result not posted as expected")

endmodule
